>>> rtl/frame_grid_event_binner_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame grid event binner
// Concurrent checks sampled on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef FRAME_GRID_EVENT_BINNER_ASSERT_SVH
`define FRAME_GRID_EVENT_BINNER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define FGEB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define FGEB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fgeb_pkg.sv
// ----------------------------------------------------------------------------
// fgeb_pkg
// Word types, field widths and codes of the frame grid event binner.
// ----------------------------------------------------------------------------
package fgeb_pkg;

  // Field widths
  localparam int unsigned FPS_W      = 10;
  localparam int unsigned FCOUNT_W   = 13;
  localparam int unsigned WIN_W      = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned STR_W      = 16;
  localparam int unsigned DELTA_W    = 16;
  localparam int unsigned METH_W     = 2;
  localparam int unsigned RFRAME_W   = 12;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned FIDX_W     = 12;
  localparam int unsigned HITS_W     = 8;
  localparam int unsigned MAG_W      = 15;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Internal arithmetic widths
  localparam int unsigned SCALED_W = TIME_W + FPS_W;  // event time in Q16.16 frames
  localparam int unsigned WLIM_W   = WIN_W + FPS_W;   // window_error * fps
  localparam int unsigned FRAME_W  = 27;              // rounded frame, with headroom
  localparam int unsigned ERR_W    = 17;              // rounding error, at most 2^15

  // Commands
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Result status
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_GRID   = 2'd1;
  localparam logic [STAT_W-1:0] ST_WINDOW = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FPS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FCOUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;

  // Register reset values
  localparam logic [FPS_W-1:0]    FPS_RST    = 10'd60;
  localparam logic [FCOUNT_W-1:0] FCOUNT_RST = 13'd0;
  localparam logic [WIN_W-1:0]    WINDOW_RST = 16'd1638;

  // Saturation limits
  localparam logic [HITS_W-1:0] HITS_MAX = 8'hFF;
  localparam logic [FIDX_W-1:0] FIDX_MAX = 12'hFFF;
  localparam logic [MAG_W-1:0]  MAG_MAX  = 15'h7FFF;

  typedef struct packed {
    logic                       cmd;
    logic [TIME_W-1:0]          event_time;
    logic [STR_W-1:0]           event_strength;
    logic signed [DELTA_W-1:0]  event_delta;
    logic [METH_W-1:0]          method_index;
    logic [RFRAME_W-1:0]        read_frame;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [FIDX_W-1:0] frame_index;
    logic [HITS_W-1:0] hit_count;
    logic [STR_W-1:0]  max_strength;
    logic [MAG_W-1:0]  max_abs_delta;
    logic [HITS_W-1:0] method_hits;
  } out_word_t;

endpackage

>>> rtl/frame_grid_event_binner.sv
// ----------------------------------------------------------------------------
// frame_grid_event_binner
// Rounds Q16.16 event times onto a frame grid, checks them against the grid
// and a timing window, and accumulates per-frame bins held in one memory.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake               | word
//   ---------+-----------+-------------------------+---------------------
//   in       | in        | in_valid / in_stall     | in_word  (in_word_t)
//   out      | out       | out_valid / out_stall   | out_word (out_word_t)
//   cfg      | in        | cfg_write               | cfg_index, cfg_data
//
// An item passes through accept, multiply, evaluate, bin memory read, and update
// and write back, one item in flight at a time; the multipliers, the window check
// and the registered memory read set these steps.
// After rst the bin memory is swept to zero, one row a cycle, over all MAX_FRAMES
// rows with in_stall held high. A finished word waits in the output register
// under out_stall while the next input word is accepted.
//
`include "frame_grid_event_binner_assert.svh"

module frame_grid_event_binner #(
  parameter int MAX_FRAMES   = 4096,
  parameter int METHOD_COUNT = 4
) (
  input  logic                                clk,
  input  logic                                rst,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  fgeb_pkg::in_word_t                  in_word,

  output logic                                out_valid,
  input  logic                                out_stall,
  output fgeb_pkg::out_word_t                 out_word,

  input  logic                                cfg_write,
  input  logic [fgeb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fgeb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Bin row layout, top to bottom: hits, peak strength, peak |delta|,
  // then one saturating counter per method.
  localparam int AW     = $clog2(MAX_FRAMES);
  localparam int MCW    = fgeb_pkg::HITS_W * METHOD_COUNT;
  localparam int DEL_LO = MCW;
  localparam int STR_LO = DEL_LO + fgeb_pkg::MAG_W;
  localparam int HIT_LO = STR_LO + fgeb_pkg::STR_W;
  localparam int RW     = HIT_LO + fgeb_pkg::HITS_W;

  localparam logic [AW-1:0] LAST_ROW = AW'(MAX_FRAMES - 1);
  localparam logic [fgeb_pkg::FRAME_W-1:0] MAX_FRAMES_F = fgeb_pkg::FRAME_W'(MAX_FRAMES);

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_MOD   = 3'd5;

  function automatic logic [fgeb_pkg::HITS_W-1:0] sat_inc(
    input logic [fgeb_pkg::HITS_W-1:0] v
  );
    return (v == fgeb_pkg::HITS_MAX) ? v : v + fgeb_pkg::HITS_W'(1);
  endfunction

  // Configuration registers
  logic [fgeb_pkg::FPS_W-1:0]    frames_per_second;
  logic [fgeb_pkg::FCOUNT_W-1:0] frame_count;
  logic [fgeb_pkg::WIN_W-1:0]    window_error;

  // Sequencer and item registers
  logic [2:0]                     state, state_next;
  logic [AW-1:0]                  clr_addr;
  fgeb_pkg::in_word_t             item;
  logic [fgeb_pkg::SCALED_W-1:0]  scaled;
  logic [fgeb_pkg::WLIM_W-1:0]    win_lim;
  logic [fgeb_pkg::FRAME_W-1:0]   frame, frame_next;
  logic [fgeb_pkg::STAT_W-1:0]    stat, stat_next;
  logic [AW-1:0]                  addr;

  // Bin memory
  logic [RW-1:0]                  bin_mem [MAX_FRAMES];
  logic [RW-1:0]                  rd_row;
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [RW-1:0]                  mem_wdata;

  // Evaluate stage
  logic [fgeb_pkg::FRAME_W-1:0]   frame_raw;
  logic [fgeb_pkg::FRAME_W-1:0]   limit;
  logic [fgeb_pkg::FRAME_W-1:0]   fcount_ext;
  logic [fgeb_pkg::FRAME_W-1:0]   rframe_ext;
  logic [fgeb_pkg::ERR_W-1:0]     round_err;

  // Update stage
  logic                           out_free;
  logic                           out_load;
  logic                           bin_write;
  logic [fgeb_pkg::DELTA_W-1:0]   abs_delta;
  logic [fgeb_pkg::MAG_W-1:0]     mag;
  logic [fgeb_pkg::HITS_W-1:0]    old_hits, new_hits;
  logic [fgeb_pkg::STR_W-1:0]     old_str, new_str;
  logic [fgeb_pkg::MAG_W-1:0]     old_del, new_del;
  logic [MCW-1:0]                 new_meth;
  logic [fgeb_pkg::HITS_W-1:0]    old_meth_sel, new_meth_sel;
  logic [RW-1:0]                  new_row;
  logic [fgeb_pkg::FIDX_W-1:0]    frame_sat;
  fgeb_pkg::out_word_t            out_word_next;

  // --------------------------------------------------------------------------
  // Configuration: write only while idle; unknown indexes drop.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_per_second <= fgeb_pkg::FPS_RST;
      frame_count       <= fgeb_pkg::FCOUNT_RST;
      window_error      <= fgeb_pkg::WINDOW_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        fgeb_pkg::REG_FPS:    frames_per_second <= cfg_data[fgeb_pkg::FPS_W-1:0];
        fgeb_pkg::REG_FCOUNT: frame_count       <= cfg_data[fgeb_pkg::FCOUNT_W-1:0];
        fgeb_pkg::REG_WINDOW: window_error      <= cfg_data[fgeb_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == S_MOD) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_addr == LAST_ROW) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_MUL;
      S_MUL:   state_next = S_EVAL;
      S_EVAL:  state_next = S_READ;
      S_READ:  state_next = S_MOD;
      S_MOD:   if (out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + AW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Accept and multiply: capture the word, then form t*fps (Q16.16 frames)
  // and the window bound window_error*fps, each in its own register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) item <= in_word;
    if (state == S_MUL) begin
      scaled  <= fgeb_pkg::SCALED_W'(item.event_time)
               * fgeb_pkg::SCALED_W'(frames_per_second);
      win_lim <= fgeb_pkg::WLIM_W'(window_error)
               * fgeb_pkg::WLIM_W'(frames_per_second);
    end
  end

  // --------------------------------------------------------------------------
  // Evaluate: round half up. The distance to the chosen grid line is just
  // the fraction, or its complement to one frame when rounding up.
  // --------------------------------------------------------------------------
  assign frame_raw  = fgeb_pkg::FRAME_W'(scaled[fgeb_pkg::SCALED_W-1:16])
                    + fgeb_pkg::FRAME_W'(scaled[15]);
  assign round_err  = scaled[15] ? (fgeb_pkg::ERR_W'(17'h10000) - fgeb_pkg::ERR_W'(scaled[15:0]))
                                 : fgeb_pkg::ERR_W'(scaled[15:0]);
  assign fcount_ext = fgeb_pkg::FRAME_W'(frame_count);
  assign limit      = (fcount_ext < MAX_FRAMES_F) ? fcount_ext : MAX_FRAMES_F;
  assign rframe_ext = fgeb_pkg::FRAME_W'(item.read_frame);

  always_comb begin
    if (item.cmd == fgeb_pkg::CMD_READ) begin
      frame_next = rframe_ext;
      stat_next  = (rframe_ext >= MAX_FRAMES_F) ? fgeb_pkg::ST_GRID : fgeb_pkg::ST_OK;
    end else begin
      frame_next = frame_raw;
      if (frame_raw == '0 || frame_raw >= limit) begin
        stat_next = fgeb_pkg::ST_GRID;
      end else if (fgeb_pkg::WLIM_W'(round_err) > win_lim) begin
        stat_next = fgeb_pkg::ST_WINDOW;
      end else begin
        stat_next = fgeb_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      frame <= frame_next;
      stat  <= stat_next;
      addr  <= frame_next[AW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Bin memory: one write port, one registered read port. One item at a
  // time, so the write back always lands before the next read.
  // --------------------------------------------------------------------------
  assign bin_write = out_load && (item.cmd == fgeb_pkg::CMD_ADD) && (stat == fgeb_pkg::ST_OK);
  assign mem_we    = (state == S_CLEAR) || bin_write;
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : addr;
  assign mem_wdata = (state == S_CLEAR) ? '0 : new_row;

  always_ff @(posedge clk) begin
    if (mem_we) bin_mem[mem_waddr] <= mem_wdata;
    if (state == S_READ && stat == fgeb_pkg::ST_OK) rd_row <= bin_mem[addr];
  end

  // --------------------------------------------------------------------------
  // Update: saturate counts, keep peaks, build the result word.
  // --------------------------------------------------------------------------
  assign old_hits = rd_row[HIT_LO +: fgeb_pkg::HITS_W];
  assign old_str  = rd_row[STR_LO +: fgeb_pkg::STR_W];
  assign old_del  = rd_row[DEL_LO +: fgeb_pkg::MAG_W];

  // |delta|, with the most negative value pinned to the largest positive one
  assign abs_delta = item.event_delta[fgeb_pkg::DELTA_W-1]
                   ? (~item.event_delta + fgeb_pkg::DELTA_W'(1))
                   : item.event_delta;
  assign mag = abs_delta[fgeb_pkg::DELTA_W-1] ? fgeb_pkg::MAG_MAX
                                              : abs_delta[fgeb_pkg::MAG_W-1:0];

  assign new_hits = sat_inc(old_hits);
  assign new_str  = (item.event_strength > old_str) ? item.event_strength : old_str;
  assign new_del  = (mag > old_del) ? mag : old_del;

  always_comb begin
    new_meth     = rd_row[MCW-1:0];
    old_meth_sel = '0;
    new_meth_sel = '0;
    for (int m = 0; m < METHOD_COUNT; m++) begin
      if (32'(item.method_index) == m) begin
        old_meth_sel = rd_row[m*fgeb_pkg::HITS_W +: fgeb_pkg::HITS_W];
        new_meth_sel = sat_inc(old_meth_sel);
        new_meth[m*fgeb_pkg::HITS_W +: fgeb_pkg::HITS_W] = new_meth_sel;
      end
    end
  end

  assign new_row   = {new_hits, new_str, new_del, new_meth};
  assign frame_sat = (frame > fgeb_pkg::FRAME_W'(fgeb_pkg::FIDX_MAX))
                   ? fgeb_pkg::FIDX_MAX : frame[fgeb_pkg::FIDX_W-1:0];

  always_comb begin
    out_word_next             = '0;
    out_word_next.status      = stat;
    out_word_next.frame_index = frame_sat;
    if (stat == fgeb_pkg::ST_OK) begin
      if (item.cmd == fgeb_pkg::CMD_ADD) begin
        out_word_next.hit_count     = new_hits;
        out_word_next.max_strength  = new_str;
        out_word_next.max_abs_delta = new_del;
        out_word_next.method_hits   = new_meth_sel;
      end else begin
        out_word_next.hit_count     = old_hits;
        out_word_next.max_strength  = old_str;
        out_word_next.max_abs_delta = old_del;
        out_word_next.method_hits   = old_meth_sel;
      end
    end
  end

  // Output register: hold the word while out_stall is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_word <= out_word_next;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `FGEB_ASSERT_NEXT(a_clear_sweep, (state == S_CLEAR && clr_addr != LAST_ROW), (clr_addr == $past(clr_addr) + AW'(1) && state == S_CLEAR), "clearing pass skipped a row")
  `FGEB_ASSERT_NOW(a_method_le_hits, (out_valid && out_word.status == fgeb_pkg::ST_OK), (out_word.method_hits <= out_word.hit_count), "method count exceeds bin hit count")
  `FGEB_ASSERT_NOW(a_reject_zero, (out_valid && out_word.status != fgeb_pkg::ST_OK), (out_word.hit_count == '0 && out_word.max_strength == '0 && out_word.max_abs_delta == '0 && out_word.method_hits == '0), "rejected word carries bin data")
  `FGEB_ASSERT_NEXT(a_write_shows, bin_write, (out_valid && out_word.hit_count == $past(new_hits)), "result does not show updated bin")

endmodule

>>> bench/frame_grid_event_binner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_grid_event_binner_tb
// Drives add and read words into the frame grid binner through random sender
// gaps and receiver stalls. A local bin model predicts every result word. A
// short table of directed words comes first, then randomized phases under
// several register settings, with one phase that drives a single bin into
// saturation.
// ----------------------------------------------------------------------------
module frame_grid_event_binner_tb;
  import fgeb_pkg::*;

  localparam int BINS        = 4096;
  localparam int METHODS     = 4;
  localparam int STALL_LIMIT = 20000;  // covers the bin sweep after reset
  localparam int SETTLE_CYC  = 10;     // settle wait after the last result
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped register index

  typedef struct {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    in_word_t              word;
    bit                    known;
    out_word_t             want;
  } plan_row_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_word   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Register shadow, starting from the reset values
  logic [FPS_W-1:0]    fps_q    = FPS_RST;
  logic [FCOUNT_W-1:0] fcount_q = FCOUNT_RST;
  logic [WIN_W-1:0]    window_q = WINDOW_RST;

  // Bin contents as the block should hold them
  logic [HITS_W-1:0] hit_mem      [BINS];
  logic [STR_W-1:0]  peak_str_mem [BINS];
  logic [MAG_W-1:0]  peak_mag_mem [BINS];
  logic [HITS_W-1:0] meth_mem     [BINS][METHODS];

  out_word_t owed_results[$];
  plan_row_t plan[$];
  int        fault_count = 0;
  int        idle_cycles = 0;
  bit        quiet       = 1'b0;  // no sender gaps and no receiver stalls

  frame_grid_event_binner #(
    .MAX_FRAMES  (BINS),
    .METHOD_COUNT(METHODS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bin model
  // --------------------------------------------------------------------------

  // Snapshot one bin as a result word.
  function automatic out_word_t bin_view(logic [STAT_W-1:0] st, logic [FIDX_W-1:0] f,
                                         logic [METH_W-1:0] m);
    out_word_t r;
    r.status        = st;
    r.frame_index   = f;
    r.hit_count     = hit_mem[f];
    r.max_strength  = peak_str_mem[f];
    r.max_abs_delta = peak_mag_mem[f];
    r.method_hits   = (int'(m) < METHODS) ? meth_mem[f][m] : '0;
    return r;
  endfunction

  // Round the event onto the grid, test it and fold it into its bin.
  function automatic out_word_t bin_event(in_word_t w);
    longint unsigned scaled, frame, lim, grid, err;
    int              d, mag, idx;
    out_word_t       r;
    r = '0;
    if (w.cmd == CMD_READ) begin
      if (int'(w.read_frame) >= BINS) begin
        r.status      = ST_GRID;
        r.frame_index = w.read_frame;
        return r;
      end
      return bin_view(ST_OK, w.read_frame, w.method_index);
    end
    // Time in Q16.16 frames, then round half up
    scaled = 64'(w.event_time) * 64'(fps_q);
    frame  = (scaled + 64'h8000) >> 16;
    lim    = 64'(fcount_q);
    if (lim > 64'(BINS)) lim = 64'(BINS);
    r.frame_index = (frame > 64'(FIDX_MAX)) ? FIDX_MAX : frame[FIDX_W-1:0];
    if (frame == 0 || frame >= lim) begin
      r.status = ST_GRID;
      return r;
    end
    // Window test on the scaled error, no division
    grid = frame << 16;
    err  = (grid >= scaled) ? grid - scaled : scaled - grid;
    if (err > 64'(window_q) * 64'(fps_q)) begin
      r.status = ST_WINDOW;
      return r;
    end
    d   = int'(w.event_delta);
    mag = (d < 0) ? -d : d;
    if (mag > int'(MAG_MAX)) mag = int'(MAG_MAX);
    idx = int'(frame);
    if (hit_mem[idx] != HITS_MAX) hit_mem[idx] = hit_mem[idx] + 1'b1;
    if (w.event_strength > peak_str_mem[idx]) peak_str_mem[idx] = w.event_strength;
    if (mag > int'(peak_mag_mem[idx])) peak_mag_mem[idx] = MAG_W'(mag);
    if (int'(w.method_index) < METHODS && meth_mem[idx][w.method_index] != HITS_MAX)
      meth_mem[idx][w.method_index] = meth_mem[idx][w.method_index] + 1'b1;
    return bin_view(ST_OK, frame[FIDX_W-1:0], w.method_index);
  endfunction

  // --------------------------------------------------------------------------
  // Word builders for the directed table
  // --------------------------------------------------------------------------

  function automatic out_word_t res(logic [STAT_W-1:0] st, int f, int hits, int str,
                                    int mag, int mh);
    out_word_t r;
    r.status        = st;
    r.frame_index   = FIDX_W'(f);
    r.hit_count     = HITS_W'(hits);
    r.max_strength  = STR_W'(str);
    r.max_abs_delta = MAG_W'(mag);
    r.method_hits   = HITS_W'(mh);
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] data);
    plan_row_t p;
    p          = '{default: '0};
    p.is_reg   = 1'b1;
    p.reg_idx  = idx;
    p.reg_data = data;
    return p;
  endfunction

  function automatic plan_row_t item_row(logic c, logic [TIME_W-1:0] t,
                                         logic [STR_W-1:0] s, logic [DELTA_W-1:0] d,
                                         logic [METH_W-1:0] m, logic [RFRAME_W-1:0] f,
                                         bit known, out_word_t want);
    plan_row_t p;
    p                     = '{default: '0};
    p.word.cmd            = c;
    p.word.event_time     = t;
    p.word.event_strength = s;
    p.word.event_delta    = d;
    p.word.method_index   = m;
    p.word.read_frame     = f;
    p.known               = known;
    p.want                = want;
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Random words
  // --------------------------------------------------------------------------

  // Most add words land close to a grid frame inside the current limit, so
  // they reach the bins; the rest are reads and raw noise. A hot draw sits tight
  // on its grid frame, mostly with method 0, to push the counters into saturation.
  function automatic in_word_t draw_word(bit hot);
    in_word_t w;
    int       lim, fr, pick;
    longint   center, span, t;
    w.cmd            = CMD_ADD;
    w.event_time     = $urandom;
    w.event_strength = STR_W'($urandom);
    w.event_delta    = DELTA_W'($urandom);
    w.method_index   = METH_W'($urandom);
    w.read_frame     = RFRAME_W'($urandom);
    lim  = (int'(fcount_q) > BINS) ? BINS : int'(fcount_q);
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) w.event_strength = '1;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: w.event_delta = 16'h8000;
        1: w.event_delta = 16'h7FFF;
        2: w.event_delta = 16'h0000;
        default: w.event_delta = 16'hFFFF;
      endcase
    end
    if (hot && $urandom_range(0, 99) < 85) w.method_index = '0;

    if (pick < (hot ? 5 : 15)) begin
      w.cmd = CMD_READ;
      if ($urandom_range(0, 1) == 0 && lim > 1)
        w.read_frame = RFRAME_W'($urandom_range(1, lim - 1));
      return w;
    end
    // Noise: keep the raw time
    if (pick < (hot ? 10 : 30) || fps_q == '0) return w;

    if (lim < 2)                        fr = $urandom_range(1, BINS - 1);
    else if ($urandom_range(0, 9) == 0) fr = $urandom_range(lim - 1, lim);
    else                                fr = $urandom_range(1, lim - 1);
    center = ((longint'(fr) << 16) + longint'(fps_q) / 2) / longint'(fps_q);
    if (hot) begin
      t = center + longint'($urandom_range(0, 200)) - 100;
    end else if ($urandom_range(0, 1) == 0) begin
      t = center;
    end else begin
      // Straddle the window edge
      span = longint'(window_q) + longint'(window_q) / 4 + 2;
      t    = center + longint'($urandom_range(0, 32'(2 * span))) - span;
    end
    if (t < 0) t = 0;
    if (t > longint'(32'hFFFF_FFFF)) t = longint'(32'hFFFF_FFFF);
    w.event_time = TIME_W'(t);
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  // Drop valid and hold off until every owed result is back, then let the
  // last item's pipeline drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_FPS:    fps_q    = data[FPS_W-1:0];
      REG_FCOUNT: fcount_q = data[FCOUNT_W-1:0];
      REG_WINDOW: window_q = data[WIN_W-1:0];
      default: ;  // unmapped index: ignore
    endcase
  endtask

  // Offer one word, with random gaps first, and hold it until accepted.
  task automatic send_word(in_word_t w, bit known, out_word_t want);
    out_word_t got;
    while (!quiet && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = bin_event(w);
    owed_results.push_back(known ? want : got);
  endtask

  // --------------------------------------------------------------------------
  // Result check, receiver stalls and watchdog
  // --------------------------------------------------------------------------

  function automatic string word_str(out_word_t w);
    return $sformatf("st=%0d frame=%0d hits=%0d str=%0d mag=%0d mhits=%0d", w.status,
                     w.frame_index, w.hit_count, w.max_strength, w.max_abs_delta,
                     w.method_hits);
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    out_stall <= !quiet && ($urandom_range(0, 99) < 10);
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
        idle_cycles = 0;
      else
        idle_cycles++;

      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          fault_count++;
          if (fault_count <= 10) $display("unexpected result word: %s", word_str(out_word));
        end else begin
          want = owed_results.pop_front();
          if (out_word.status        !== want.status       ||
              out_word.frame_index   !== want.frame_index  ||
              out_word.hit_count     !== want.hit_count    ||
              out_word.max_strength  !== want.max_strength ||
              out_word.max_abs_delta !== want.max_abs_delta ||
              out_word.method_hits   !== want.method_hits) begin
            fault_count++;
            if (fault_count <= 10)
              $display("result mismatch at %0t: expected %s, got %s", $realtime,
                       word_str(want), word_str(out_word));
          end
        end
      end

      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  initial begin
    logic [CFG_DATA_W-1:0] fps_w, cnt_w, win_w;
    int                    n;
    bit                    hot;

    for (int i = 0; i < BINS; i++) begin
      hit_mem[i]      = '0;
      peak_str_mem[i] = '0;
      peak_mag_mem[i] = '0;
      for (int m = 0; m < METHODS; m++) meth_mem[i][m] = '0;
    end

    // Directed table. Under the reset settings the grid is empty, so every
    // add is outside the grid; the rows after that walk the frame limit,
    // the window edge, the delta extremes and a zero frame rate.
    plan.push_back(item_row(CMD_READ, 0, 0, 0, 0, 0, 1, res(ST_OK, 0, 0, 0, 0, 0)));
    plan.push_back(item_row(CMD_READ, 0, 0, 0, 3, 4095, 1,
                            res(ST_OK, 4095, 0, 0, 0, 0)));
    plan.push_back(item_row(CMD_ADD, 32'h0001_0000, 7, 7, 0, 0, 1,
                            res(ST_GRID, 60, 0, 0, 0, 0)));
    plan.push_back(item_row(CMD_ADD, 32'hFFFF_FFFF, 7, 7, 0, 0, 1,
                            res(ST_GRID, 4095, 0, 0, 0, 0)));
    plan.push_back(reg_row(REG_FCOUNT, 16'd4096));
    // First and last frame of the grid; most negative delta saturates
    plan.push_back(item_row(CMD_ADD, 1092, 16'hFFFF, 16'h8000, 3, 0, 1,
                            res(ST_OK, 1, 1, 65535, 32767, 1)));
    plan.push_back(item_row(CMD_ADD, 4472832, 1, 16'h7FFF, 0, 0, 1,
                            res(ST_OK, 4095, 1, 1, 32767, 1)));
    plan.push_back(item_row(CMD_ADD, 4473924, 1, 1, 0, 0, 1,
                            res(ST_GRID, 4095, 0, 0, 0, 0)));
    // Zero window: only exact grid times pass
    plan.push_back(reg_row(REG_WINDOW, 16'd0));
    plan.push_back(item_row(CMD_ADD, 1092, 5, 5, 1, 0, 1,
                            res(ST_WINDOW, 1, 0, 0, 0, 0)));
    plan.push_back(item_row(CMD_ADD, 16384, 0, 0, 2, 0, 1, res(ST_OK, 15, 1, 0, 0, 1)));
    plan.push_back(item_row(CMD_ADD, 16384, 0, 16'h7FFF, 2, 0, 1,
                            res(ST_OK, 15, 2, 0, 32767, 2)));
    plan.push_back(item_row(CMD_ADD, 16384, 16'h8000, 16'hFFFF, 1, 0, 1,
                            res(ST_OK, 15, 3, 32768, 32767, 1)));
    plan.push_back(item_row(CMD_READ, 0, 0, 0, 2, 15, 1,
                            res(ST_OK, 15, 3, 32768, 32767, 2)));
    plan.push_back(item_row(CMD_READ, 0, 0, 0, 3, 1, 1,
                            res(ST_OK, 1, 1, 65535, 32767, 1)));
    // Zero frame rate puts everything on frame 0
    plan.push_back(reg_row(REG_FPS, 16'd0));
    plan.push_back(item_row(CMD_ADD, 32'hFFFF_FFFF, 9, 9, 0, 0, 1,
                            res(ST_GRID, 0, 0, 0, 0, 0)));
    // Top frame rate with the upper data bits set, widest window
    plan.push_back(reg_row(REG_FPS, 16'hFFE8));
    plan.push_back(reg_row(REG_WINDOW, 16'hFFFF));
    plan.push_back(item_row(CMD_ADD, 0, 9, 9, 0, 0, 1, res(ST_GRID, 0, 0, 0, 0, 0)));
    plan.push_back(item_row(CMD_ADD, 65, 100, 16'hFED4, 0, 0, 0, '0));
    // Frame count beyond storage clamps to the bin count
    plan.push_back(reg_row(REG_FCOUNT, 16'hFFFF));
    plan.push_back(item_row(CMD_ADD, 268370, 200, 16'h0123, 1, 0, 0, '0));
    plan.push_back(reg_row(REG_SPARE, 16'hFFFF));
    plan.push_back(item_row(CMD_ADD, 268370, 300, 16'h8001, 1, 0, 0, '0));
    plan.push_back(reg_row(REG_FCOUNT, 16'd1));
    plan.push_back(item_row(CMD_ADD, 65, 9, 9, 0, 0, 1, res(ST_GRID, 1, 0, 0, 0, 0)));
    plan.push_back(item_row(CMD_READ, 0, 0, 0, 1, 4095, 0, '0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_reg) write_reg(plan[i].reg_idx, plan[i].reg_data);
      else send_word(plan[i].word, plan[i].known, plan[i].want);
    end

    // Randomized phases, each under its own register setting. Every phase
    // starts from an idle block, so the sender pauses for all results here.
    for (int p = 0; p < 8; p++) begin
      hot   = 1'b0;
      quiet = 1'b0;
      n     = 160;
      case (p)
        0: begin fps_w = 16'd60; cnt_w = 16'd4096; win_w = 16'd1638; n = 220; end
        1: begin fps_w = 16'd1;  cnt_w = 16'd4096; win_w = 16'd0;    n = 220; end
        2: begin
          fps_w = 16'hFFE8; cnt_w = 16'hFFFF; win_w = 16'hFFFF; n = 220;
          quiet = 1'b1;
        end
        3: begin
          // Single usable frame: saturate its counters
          fps_w = 16'd25; cnt_w = 16'd2; win_w = 16'hFFFF; n = 400;
          hot   = 1'b1;
        end
        7: begin
          fps_w = CFG_DATA_W'($urandom);
          cnt_w = CFG_DATA_W'($urandom);
          win_w = CFG_DATA_W'($urandom);
        end
        default: begin
          fps_w = CFG_DATA_W'($urandom_range(1, 1000));
          cnt_w = CFG_DATA_W'($urandom_range(0, 8191));
          win_w = CFG_DATA_W'($urandom);
        end
      endcase
      write_reg(REG_FPS, fps_w);
      write_reg(REG_FCOUNT, cnt_w);
      write_reg(REG_WINDOW, win_w);
      for (int k = 0; k < n; k++) send_word(draw_word(hot), 1'b0, '0);
    end

    quiet    = 1'b0;
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (4 * SETTLE_CYC) @(posedge clk);

    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
